// File: hw/rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg: shared types and constants for the positional list
// Sizes, operation codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // entry address
    localparam int CW       = $clog2(CAPACITY + 1);                  // entry count
    localparam int POS_W    = 5;
    localparam int LW       = (CW > POS_W) ? CW : POS_W;             // compare width
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_LOOP,
        ST_INS_WR,
        ST_DEL_SCAN,
        ST_DEL_CMP,
        ST_DEL_SH,
        ST_DEL_SHWR,
        ST_RD_WAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LD_CNT,
        IDX_LD_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RS_IDX,
        RS_IDX_M1,
        RS_IDX_P1,
        RS_POS
    } t_rsel;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_ONES,
        RV_RDATA
    } t_rv_sel;

    typedef struct packed {
        logic    cap;       // capture request fields
        t_idx_op idx_op;
        logic    rd;        // RAM read
        t_rsel   rsel;
        logic    wr;        // RAM write at idx
        logic    wr_val;    // write request value instead of read data
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_set;   // stage result
        logic    res_ok;
        t_rv_sel rv_sel;
        logic    out_load;  // move staged result to output register
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_ok;
        logic              rd_ok;
        logic              idx_gt_pos;
        logic              idx_lt_cnt;
        logic              idx_p1_lt_cnt;
        logic              match;
        logic              out_free;
    } t_stat;

endpackage

// File: hw/rtl/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl: operation sequencer
// Walks insert shifts, delete search and close-up, and reads, at most one RAM
// access per cycle, then hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module plist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  plist_pkg::t_stat i_stat,
    output plist_pkg::t_cmd  o_cmd
);
    import plist_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.rsel   = RS_IDX;
        o_cmd.rv_sel = RV_ZERO;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.ins_ok) begin
                            o_cmd.idx_op = IDX_LD_CNT;
                            n_state      = ST_INS_LOOP;
                        end else begin
                            o_cmd.res_set = 1'b1;
                            n_state       = ST_FINISH;
                        end
                    end
                    FUNC_DELETE: begin
                        o_cmd.idx_op = IDX_LD_ZERO;
                        n_state      = ST_DEL_SCAN;
                    end
                    FUNC_READ: begin
                        if (i_stat.rd_ok) begin
                            o_cmd.rd   = 1'b1;
                            o_cmd.rsel = RS_POS;
                            n_state    = ST_RD_WAIT;
                        end else begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.rv_sel  = RV_ONES;
                            n_state       = ST_FINISH;
                        end
                    end
                    default: begin
                        o_cmd.res_set = 1'b1;
                        n_state       = ST_FINISH;
                    end
                endcase
            end
            ST_INS_LOOP: begin
                if (i_stat.idx_gt_pos) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.rsel = RS_IDX_M1;
                    n_state    = ST_INS_WR;
                end else begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_ok  = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_INS_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.idx_op = IDX_DEC;
                n_state      = ST_INS_LOOP;
            end
            ST_DEL_SCAN: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.rsel = RS_IDX;
                    n_state    = ST_DEL_CMP;
                end else begin
                    o_cmd.res_set = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_DEL_CMP: begin
                if (i_stat.match) begin
                    n_state = ST_DEL_SH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = ST_DEL_SCAN;
                end
            end
            ST_DEL_SH: begin
                if (i_stat.idx_p1_lt_cnt) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.rsel = RS_IDX_P1;
                    n_state    = ST_DEL_SHWR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_ok  = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_DEL_SHWR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.idx_op = IDX_INC;
                n_state      = ST_DEL_SH;
            end
            ST_RD_WAIT: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_ok  = 1'b1;
                o_cmd.rv_sel  = RV_RDATA;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/plist_dp.sv
// ----------------------------------------------------------------------------
// plist_dp: list datapath
// Request registers, walk index, entry count, entry RAM and result registers.
// ----------------------------------------------------------------------------
module plist_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [plist_pkg::IN_W-1:0]    i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [plist_pkg::OUT_W-1:0]   o_m_tdata,
    input  plist_pkg::t_cmd               i_cmd,
    output plist_pkg::t_stat              o_stat
);
    import plist_pkg::*;

    logic [FUNC_W-1:0] r_func;
    logic [VAL_W-1:0]  r_value;
    logic [POS_W-1:0]  r_pos;
    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     n_idx;
    logic [CW-1:0]     r_count;
    logic              r_res_ok;
    logic [VAL_W-1:0]  r_res_rv;
    logic              r_out_valid;
    logic              r_out_ok;
    logic [VAL_W-1:0]  r_out_rv;
    logic [POS_W-1:0]  r_out_cnt;

    logic [LW-1:0]     cnt_x;
    logic [LW-1:0]     pos_x;
    logic [LW-1:0]     idx_p1;
    logic [LW-1:0]     raddr_x;
    logic [VAL_W-1:0]  rdata;
    logic [VAL_W-1:0]  wdata;

    assign cnt_x  = LW'(r_count);
    assign pos_x  = LW'(r_pos);
    assign idx_p1 = r_idx + 1'b1;

    always_comb begin
        case (i_cmd.rsel)
            RS_IDX:    raddr_x = r_idx;
            RS_IDX_M1: raddr_x = r_idx - 1'b1;
            RS_IDX_P1: raddr_x = idx_p1;
            RS_POS:    raddr_x = pos_x;
            default:   raddr_x = r_idx;
        endcase
    end

    assign wdata = i_cmd.wr_val ? r_value : rdata;

    plist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr_x[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        case (i_cmd.idx_op)
            IDX_HOLD:    n_idx = r_idx;
            IDX_LD_CNT:  n_idx = cnt_x;
            IDX_LD_ZERO: n_idx = '0;
            IDX_INC:     n_idx = idx_p1;
            IDX_DEC:     n_idx = r_idx - 1'b1;
            default:     n_idx = r_idx;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func  <= i_s_tdata[FUNC_W-1:0];
            r_value <= i_s_tdata[FUNC_W +: VAL_W];
            r_pos   <= i_s_tdata[FUNC_W+VAL_W +: POS_W];
        end
        r_idx <= n_idx;
        if (i_cmd.res_set) begin
            r_res_ok <= i_cmd.res_ok;
            case (i_cmd.rv_sel)
                RV_ZERO:  r_res_rv <= '0;
                RV_ONES:  r_res_rv <= '1;
                RV_RDATA: r_res_rv <= rdata;
                default:  r_res_rv <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_ok  <= r_res_ok;
            r_out_rv  <= r_res_rv;
            r_out_cnt <= cnt_x[POS_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.func          = r_func;
    assign o_stat.ins_ok        = (pos_x <= cnt_x) && (cnt_x < LW'(CAPACITY));
    assign o_stat.rd_ok         = (pos_x < cnt_x);
    assign o_stat.idx_gt_pos    = (r_idx > pos_x);
    assign o_stat.idx_lt_cnt    = (r_idx < cnt_x);
    assign o_stat.idx_p1_lt_cnt = (idx_p1 < cnt_x);
    assign o_stat.match         = (rdata == r_value);
    assign o_stat.out_free      = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - 1 - VAL_W - POS_W){1'b0}}, r_out_cnt, r_out_rv, r_out_ok};

endmodule

// File: hw/rtl/positional_list_insert_delete_read_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_read_top: bounded ordered list of 32-bit values
// Insert at position, delete first match, read at position; one result each.
// ----------------------------------------------------------------------------
// Steps from accept to result (n = entry count, one RAM access a cycle):
//   read: RAM read, then staged; failed read/insert, func 3: staged at dispatch
//   insert: read/write per shift, n down to position; delete: scan, then close-up
// One request in flight; the next is taken the cycle after its result moves to
// the output register; a stalled output holds the result back until then.
// Reset (synchronous, active low) empties the list; entries are not cleared.
module positional_list_insert_delete_read_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request: [1:0] func, [33:2] value, [38:34] position, [39] zero
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [plist_pkg::IN_W-1:0]  i_s_tdata,
    // result: [0] ok, [32:1] read_value, [37:33] entry_count, [39:38] zero
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [plist_pkg::OUT_W-1:0] o_m_tdata
);
    import plist_pkg::*;

    t_cmd  cmd;   // sequencer commands to the datapath
    t_stat stat;  // compare results and output-slot status back

    // Sequencer: one state per RAM access of the insert/delete walks.
    plist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: entry RAM, count, walk index and output register.
    plist_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

// File: hw/rtl/plist_chk.sv
// ----------------------------------------------------------------------------
// plist_chk: port-level checker for the positional list
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module plist_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        o_s_tready,
    input  logic [plist_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [plist_pkg::OUT_W-1:0] o_m_tdata
);
    import plist_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in flight");

    // failed operation reports 0 or -1 only
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |->
            (o_m_tdata[VAL_W:1] == '0) || (o_m_tdata[VAL_W:1] == '1))
        else $error("failed operation with stray read value");

    // count never exceeds capacity, pad bits zero
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (POS_W'(o_m_tdata[VAL_W+1 +: POS_W]) <= POS_W'(CAPACITY)
                        || CAPACITY > 31) && (o_m_tdata[OUT_W-1:VAL_W+POS_W+1] == '0))
        else $error("entry count out of range");

endmodule

bind positional_list_insert_delete_read_top plist_chk u_plist_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
